### rtl/core/rxd_pkg.sv
// Package for the RLE / XOR-delta frame decoder.
// Holds mode, status and packet phase codes, and the controller/datapath link types.
// No dependencies.
package rxd_pkg;

   localparam int unsigned REGION_WIDTH = 17;

   localparam logic [1:0] MODE_RAW    = 2'd0;
   localparam logic [1:0] MODE_XOR    = 2'd1;
   localparam logic [1:0] MODE_RLE    = 2'd2;
   localparam logic [1:0] MODE_RLEXOR = 2'd3;

   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_LENGTH  = 3'd1;
   localparam logic [2:0] STAT_MODE    = 3'd2;
   localparam logic [2:0] STAT_NO_REF  = 3'd3;
   localparam logic [2:0] STAT_OVERRUN = 3'd4;

   localparam logic [1:0] PHASE_TAG     = 2'd0;
   localparam logic [1:0] PHASE_REPEAT  = 2'd1;
   localparam logic [1:0] PHASE_LITERAL = 2'd2;

   localparam int unsigned TAG_REPEAT_BIT = 7;
   localparam logic [7:0]  TAG_COUNT_MASK = 8'h7F;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECODE = 5'b00010,
      S_READ   = 5'b00100,
      S_WRITE  = 5'b01000,
      S_FINISH = 5'b10000
   } rxd_state_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic read;
      logic write;
      logic finish;
   } rxd_cmd_type;

   typedef struct packed {
      logic run_nonzero;
      logic xor_mode;
      logic last_pixel;
      logic hold_full;
      logic out_free;
      logic finish_emit;
   } rxd_status_type;

endpackage

### rtl/core/rxd_ctrl.sv
// Controller of the frame decoder: sequences capture, decode, pixel read/write and finish.
// Depends on rxd_pkg; drives the datapath by rxd_cmd_type, reads rxd_status_type.
module rxd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rxd_pkg::rxd_status_type status,
   output rxd_pkg::rxd_cmd_type    cmd
);

   rxd_pkg::rxd_state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         rxd_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = rxd_pkg::S_DECODE;
            end
         end
         rxd_pkg::S_DECODE: begin
            cmd.decode = 1'b1;
            if (!status.run_nonzero) begin
               state_in = rxd_pkg::S_FINISH;
            end else if (status.xor_mode) begin
               state_in = rxd_pkg::S_READ;
            end else begin
               state_in = rxd_pkg::S_WRITE;
            end
         end
         rxd_pkg::S_READ: begin
            cmd.read = 1'b1;
            state_in = rxd_pkg::S_WRITE;
         end
         rxd_pkg::S_WRITE: begin
            if (!status.hold_full || status.out_free) begin
               cmd.write = 1'b1;
               if (status.last_pixel) begin
                  state_in = rxd_pkg::S_FINISH;
               end else if (status.xor_mode) begin
                  state_in = rxd_pkg::S_READ;
               end else begin
                  state_in = rxd_pkg::S_WRITE;
               end
            end
         end
         rxd_pkg::S_FINISH: begin
            if (!status.finish_emit || status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = rxd_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rxd_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rxd_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/rxd_datapath.sv
// Datapath of the frame decoder: frame state, reference store, pixel pairing, result register.
// Depends on rxd_pkg; commanded by rxd_ctrl.
module rxd_datapath #(
   parameter int unsigned MAX_PIXELS = 65536
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rxd_pkg::rxd_cmd_type                 cmd,
   output rxd_pkg::rxd_status_type              status,
   input  logic [7:0]                           req_payload_byte,
   input  logic                                 req_payload_end,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rxd_pkg::REGION_WIDTH-1:0]     csr_region_pixels,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [7:0]                           rsp_index_first,
   output logic [7:0]                           rsp_index_second,
   output logic [1:0]                           rsp_index_count,
   output logic                                 rsp_frame_done,
   output logic [2:0]                           rsp_frame_status,
   output logic                                 rsp_run_last
);

   localparam int unsigned PW = $clog2(MAX_PIXELS + 1);
   localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int unsigned LW = (PW > rxd_pkg::REGION_WIDTH) ? PW : rxd_pkg::REGION_WIDTH;

   logic [7:0]                       byte_ff;
   logic                             end_ff;
   logic [rxd_pkg::REGION_WIDTH-1:0] region_ff, region_in;
   logic                             have_ref_ff, have_ref_in;
   logic [1:0]                       mode_ff, mode_in;
   logic                             expect_ff, expect_in;
   logic [PW-1:0]                    pos_ff, pos_in;
   logic [1:0]                       phase_ff, phase_in;
   logic [7:0]                       litrem_ff, litrem_in;
   logic [2:0]                       err_ff, err_in;
   logic [7:0]                       cnt_ff, cnt_in;
   logic                             flush_ff, flush_in;
   logic [1:0]                       hc_ff, hc_in;
   logic [7:0]                       h0_ff, h0_in;
   logic [7:0]                       h1_ff, h1_in;
   logic [7:0]                       rdata_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [7:0]                       first_ff, second_ff;
   logic [1:0]                       count_ff;
   logic                             done_ff, last_ff;
   logic [2:0]                       stat_ff;

   logic [7:0] ref_mem [MAX_PIXELS];

   logic [PW-1:0] reg_lim;
   logic          xor_mode;
   logic [7:0]    pixel;
   logic [7:0]    run_len;
   logic [PW:0]   run_end;
   logic [2:0]    err_fin;
   logic          out_free;
   logic          emit;
   logic [7:0]    e_first, e_second;
   logic [1:0]    e_count;
   logic          e_done, e_last;
   logic [2:0]    e_stat;
   logic [7:0]    dec_cnt;

   assign csr_ready = 1'b1;

   always_comb begin
      if (region_ff == '0) begin
         reg_lim = PW'(1);
      end else if (LW'(region_ff) > LW'(MAX_PIXELS)) begin
         reg_lim = PW'(MAX_PIXELS);
      end else begin
         reg_lim = PW'(region_ff);
      end
   end

   assign xor_mode = (mode_ff == rxd_pkg::MODE_XOR) || (mode_ff == rxd_pkg::MODE_RLEXOR);
   assign pixel    = xor_mode ? (byte_ff ^ rdata_ff) : byte_ff;
   assign run_len  = (byte_ff & rxd_pkg::TAG_COUNT_MASK) + 8'd1;
   assign run_end  = {1'b0, pos_ff} + (PW+1)'(run_len);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      err_fin = err_ff;
      if (err_ff == rxd_pkg::STAT_OK) begin
         if (((mode_ff == rxd_pkg::MODE_RLE) || (mode_ff == rxd_pkg::MODE_RLEXOR))
             && (phase_ff != rxd_pkg::PHASE_TAG)) begin
            err_fin = rxd_pkg::STAT_LENGTH;
         end else if (pos_ff != reg_lim) begin
            err_fin = rxd_pkg::STAT_LENGTH;
         end
      end
   end

   always_comb begin
      dec_cnt = 8'd0;
      if (!expect_ff && (err_ff == rxd_pkg::STAT_OK)) begin
         if ((mode_ff == rxd_pkg::MODE_RAW) || (mode_ff == rxd_pkg::MODE_XOR)) begin
            dec_cnt = (pos_ff >= reg_lim) ? 8'd0 : 8'd1;
         end else if (phase_ff == rxd_pkg::PHASE_REPEAT) begin
            dec_cnt = litrem_ff;
         end else if (phase_ff == rxd_pkg::PHASE_LITERAL) begin
            dec_cnt = 8'd1;
         end
      end
   end

   always_comb begin
      region_in    = region_ff;
      have_ref_in  = have_ref_ff;
      mode_in      = mode_ff;
      expect_in    = expect_ff;
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      litrem_in    = litrem_ff;
      err_in       = err_ff;
      cnt_in       = cnt_ff;
      flush_in     = flush_ff;
      hc_in        = hc_ff;
      h0_in        = h0_ff;
      h1_in        = h1_ff;
      emit         = 1'b0;
      e_first      = h0_ff;
      e_second     = h1_ff;
      e_count      = 2'd2;
      e_done       = 1'b0;
      e_stat       = rxd_pkg::STAT_OK;
      e_last       = 1'b1;

      if (csr_valid) begin
         region_in = csr_region_pixels;
      end

      if (cmd.decode) begin
         flush_in = 1'b0;
         cnt_in   = dec_cnt;
         if (expect_ff) begin
            expect_in = 1'b0;
            pos_in    = '0;
            phase_in  = rxd_pkg::PHASE_TAG;
            litrem_in = 8'd0;
            err_in    = rxd_pkg::STAT_OK;
            if (byte_ff > {6'd0, rxd_pkg::MODE_RLEXOR}) begin
               mode_in = rxd_pkg::MODE_RAW;
               err_in  = rxd_pkg::STAT_MODE;
            end else begin
               mode_in = byte_ff[1:0];
               if (((byte_ff[1:0] == rxd_pkg::MODE_XOR) || (byte_ff[1:0] == rxd_pkg::MODE_RLEXOR))
                   && !have_ref_ff) begin
                  err_in = rxd_pkg::STAT_NO_REF;
               end
            end
         end else if (err_ff == rxd_pkg::STAT_OK) begin
            if ((mode_ff == rxd_pkg::MODE_RAW) || (mode_ff == rxd_pkg::MODE_XOR)) begin
               if (pos_ff >= reg_lim) begin
                  err_in = rxd_pkg::STAT_LENGTH;
               end
            end else if (phase_ff == rxd_pkg::PHASE_TAG) begin
               flush_in = byte_ff[rxd_pkg::TAG_REPEAT_BIT];
               if (run_end > {1'b0, reg_lim}) begin
                  err_in = rxd_pkg::STAT_OVERRUN;
               end else begin
                  phase_in  = byte_ff[rxd_pkg::TAG_REPEAT_BIT] ? rxd_pkg::PHASE_REPEAT
                                                              : rxd_pkg::PHASE_LITERAL;
                  litrem_in = run_len;
               end
            end else if (phase_ff == rxd_pkg::PHASE_REPEAT) begin
               phase_in  = rxd_pkg::PHASE_TAG;
               litrem_in = 8'd0;
            end else begin
               litrem_in = litrem_ff - 8'd1;
               if (litrem_ff == 8'd1) begin
                  phase_in = rxd_pkg::PHASE_TAG;
               end
            end
         end
      end

      if (cmd.write) begin
         pos_in = pos_ff + PW'(1);
         cnt_in = cnt_ff - 8'd1;
         if (hc_ff == 2'd2) begin
            emit   = 1'b1;
            e_last = !end_ff && (cnt_ff == 8'd1);
            h0_in  = pixel;
            hc_in  = 2'd1;
         end else if (hc_ff == 2'd1) begin
            h1_in = pixel;
            hc_in = 2'd2;
         end else begin
            h0_in = pixel;
            hc_in = 2'd1;
         end
      end

      if (cmd.finish) begin
         if (end_ff) begin
            emit      = 1'b1;
            e_first   = (hc_ff != 2'd0) ? h0_ff : 8'd0;
            e_second  = (hc_ff == 2'd2) ? h1_ff : 8'd0;
            e_count   = hc_ff;
            e_done    = 1'b1;
            e_stat    = err_fin;
            err_in    = err_fin;
            hc_in     = 2'd0;
            expect_in = 1'b1;
            phase_in  = rxd_pkg::PHASE_TAG;
            litrem_in = 8'd0;
            if (err_fin == rxd_pkg::STAT_OK) begin
               have_ref_in = 1'b1;
            end
         end else if (hc_ff == 2'd2) begin
            emit  = 1'b1;
            hc_in = 2'd0;
         end else if ((hc_ff == 2'd1) && flush_ff) begin
            emit     = 1'b1;
            e_second = 8'd0;
            e_count  = 2'd1;
            hc_in    = 2'd0;
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff    <= rxd_pkg::REGION_WIDTH'(65536);
         have_ref_ff  <= 1'b0;
         mode_ff      <= rxd_pkg::MODE_RAW;
         expect_ff    <= 1'b1;
         pos_ff       <= '0;
         phase_ff     <= rxd_pkg::PHASE_TAG;
         litrem_ff    <= 8'd0;
         err_ff       <= rxd_pkg::STAT_OK;
         cnt_ff       <= 8'd0;
         flush_ff     <= 1'b0;
         hc_ff        <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         region_ff    <= region_in;
         have_ref_ff  <= have_ref_in;
         mode_ff      <= mode_in;
         expect_ff    <= expect_in;
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         litrem_ff    <= litrem_in;
         err_ff       <= err_in;
         cnt_ff       <= cnt_in;
         flush_ff     <= flush_in;
         hc_ff        <= hc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      h0_ff <= h0_in;
      h1_ff <= h1_in;
      if (cmd.capture) begin
         byte_ff <= req_payload_byte;
         end_ff  <= req_payload_end;
      end
      if (emit) begin
         first_ff  <= e_first;
         second_ff <= e_second;
         count_ff  <= e_count;
         done_ff   <= e_done;
         stat_ff   <= e_stat;
         last_ff   <= e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         ref_mem[pos_ff[AW-1:0]] <= pixel;
      end
      if (cmd.read) begin
         rdata_ff <= ref_mem[pos_ff[AW-1:0]];
      end
   end

   assign status.run_nonzero = (dec_cnt != 8'd0);
   assign status.xor_mode    = xor_mode;
   assign status.last_pixel  = (cnt_ff == 8'd1);
   assign status.hold_full   = (hc_ff == 2'd2);
   assign status.out_free    = out_free;
   assign status.finish_emit = end_ff || (hc_ff == 2'd2) || ((hc_ff == 2'd1) && flush_ff);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_index_first  = first_ff;
   assign rsp_index_second = second_ff;
   assign rsp_index_count  = count_ff;
   assign rsp_frame_done   = done_ff;
   assign rsp_frame_status = stat_ff;
   assign rsp_run_last     = last_ff;

endmodule

### rtl/core/rle_xor_delta_frame_decoder_unit.sv
// Top level of the RLE / XOR-delta frame decoder.
// Depends on rxd_pkg, rxd_ctrl and rxd_datapath.
//
// Usage:
//   req_*  : one payload byte per transaction; the first byte of a payload is the
//            mode, req_payload_end marks the last byte.
//   rsp_*  : up to two decoded index pixels per transaction; the transaction that
//            closes a payload carries frame_done and frame_status; run_last marks
//            the last transaction caused by one request.
//   csr_*  : region size in pixels, always ready; write only while idle.
// Steps: each byte walks capture, decode, pixel steps and finish; a mode byte or a tag
//   has no pixel steps. In XOR modes each pixel reads the reference store through its
//   single registered read port before it is written.
// The result register decouples the channels: a new byte is accepted while a
//   result waits; a stalled receiver holds the decoder only when a further result
//   must be placed. Nothing is lost while rsp_ready is low.
// Reset: control state clears, region returns to 65536 and no
//   reference is present; the reference store itself is not cleared.
module rle_xor_delta_frame_decoder_unit #(
   parameter int unsigned MAX_PIXELS = 65536
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_payload_byte,
   input  logic                             req_payload_end,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_index_first,
   output logic [7:0]                       rsp_index_second,
   output logic [1:0]                       rsp_index_count,
   output logic                             rsp_frame_done,
   output logic [2:0]                       rsp_frame_status,
   output logic                             rsp_run_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rxd_pkg::REGION_WIDTH-1:0] csr_region_pixels
);

   rxd_pkg::rxd_cmd_type    cmd;
   rxd_pkg::rxd_status_type status;

   rxd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rxd_datapath #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_payload_byte  (req_payload_byte),
      .req_payload_end   (req_payload_end),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_region_pixels (csr_region_pixels),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_index_first   (rsp_index_first),
      .rsp_index_second  (rsp_index_second),
      .rsp_index_count   (rsp_index_count),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_run_last      (rsp_run_last)
   );

endmodule

### rtl/core/rxd_checker.sv
// Port-level checker for the RLE / XOR-delta frame decoder, bound to the top level.
// Depends on rxd_pkg and the top level's port list.
module rxd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_index_first,
   input logic [7:0] rsp_index_second,
   input logic [1:0] rsp_index_count,
   input logic       rsp_frame_done,
   input logic [2:0] rsp_frame_status,
   input logic       rsp_run_last
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index_first)
         && $stable(rsp_index_second) && $stable(rsp_index_count)
         && $stable(rsp_frame_done) && $stable(rsp_frame_status) && $stable(rsp_run_last))
      else $error("stalled result changed");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_run_last)
      else $error("closing result not marked last");

   a_status_only_at_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |-> rsp_frame_status == rxd_pkg::STAT_OK
         && rsp_index_count == 2'd2
         || rsp_valid && !rsp_frame_done && rsp_index_count == 2'd1
         && rsp_frame_status == rxd_pkg::STAT_OK)
      else $error("status or count invalid on a mid-frame result");

   a_unused_pixels_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_count != 2'd2 |-> rsp_index_second == 8'd0
         && (rsp_index_count != 2'd0 || rsp_index_first == 8'd0))
      else $error("pixel beyond count not zero");

endmodule

bind rle_xor_delta_frame_decoder_unit rxd_checker u_rxd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_index_first  (rsp_index_first),
   .rsp_index_second (rsp_index_second),
   .rsp_index_count  (rsp_index_count),
   .rsp_frame_done   (rsp_frame_done),
   .rsp_frame_status (rsp_frame_status),
   .rsp_run_last     (rsp_run_last)
);

### tb/sv/rle_xor_delta_frame_decoder_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for rle_xor_delta_frame_decoder_unit: queued payload bytes feed a
// clocked driver, a clocked monitor checks every result against a built-in frame decoder.
// Depends on rxd_pkg and the decoder RTL.
module rle_xor_delta_frame_decoder_unit_test;

   localparam int unsigned MAX_PIXELS    = 65536;
   localparam int          SETTLE_CYCLES = 300;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } payload_item_type;

   typedef struct packed {
      logic [7:0] px_first;
      logic [7:0] px_second;
      logic [1:0] count;
      logic       done;
      logic [2:0] status;
      logic       last;
   } index_beat_type;

   typedef enum int {FRAME_GOOD, FRAME_BAD_MODE, FRAME_BAD_LENGTH, FRAME_BAD_PACKET}
      frame_kind_type;
   typedef enum int {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_EVERY_THIRD}
      ready_style_type;

   logic                             clock;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [7:0]                       req_payload_byte = 8'h00;
   logic                             req_payload_end = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [7:0]                       rsp_index_first;
   logic [7:0]                       rsp_index_second;
   logic [1:0]                       rsp_index_count;
   logic                             rsp_frame_done;
   logic [2:0]                       rsp_frame_status;
   logic                             rsp_run_last;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [rxd_pkg::REGION_WIDTH-1:0] csr_region_pixels = '0;

   // decoder state as predicted
   logic [7:0]  ref_store [0:MAX_PIXELS-1];
   logic        have_ref = 1'b0;
   logic [1:0]  cur_mode = rxd_pkg::MODE_RAW;
   logic        want_mode = 1'b1;
   int unsigned pix_pos = 0;
   logic [1:0]  phase = rxd_pkg::PHASE_TAG;
   logic [7:0]  lit_left = 8'd0;
   logic [2:0]  err = rxd_pkg::STAT_OK;
   logic [16:0] region_reg = 17'd65536;
   logic        held_valid = 1'b0;
   logic [7:0]  held_px = 8'd0;

   payload_item_type pending [$];
   index_beat_type   expected_beats [$];
   logic [7:0]       frame_bytes [$];
   payload_item_type next_item;
   index_beat_type   want_beat;

   logic            in_flight = 1'b0;
   int              burst_left = 8;
   int              gap_left = 0;
   int              items_accepted = 0;
   int              results_checked = 0;
   int              mismatch_count = 0;
   int              status_tally [5] = '{0, 0, 0, 0, 0};
   int unsigned     gen_prefix = 0;
   int              random_items = 0;
   ready_style_type stall_style = READY_ALWAYS;
   int              stall_cycle = 0;
   int              long_hold_left = 0;
   logic            long_hold_used = 1'b0;

   rle_xor_delta_frame_decoder_unit #(.MAX_PIXELS(MAX_PIXELS)) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_payload_byte  (req_payload_byte),
      .req_payload_end   (req_payload_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_index_first   (rsp_index_first),
      .rsp_index_second  (rsp_index_second),
      .rsp_index_count   (rsp_index_count),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_run_last      (rsp_run_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_region_pixels (csr_region_pixels)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #24_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int unsigned effective_region(input logic [16:0] value);
      if (value == 0) return 1;
      if (value > MAX_PIXELS) return MAX_PIXELS;
      return 32'(value);
   endfunction

   function automatic logic [7:0] store_pixel(input logic [7:0] b);
      logic [7:0] v;
      v = b;
      if (cur_mode == rxd_pkg::MODE_XOR || cur_mode == rxd_pkg::MODE_RLEXOR)
         v = b ^ ref_store[pix_pos];
      ref_store[pix_pos] = v;
      pix_pos++;
      return v;
   endfunction

   function automatic void add_beat(input logic [7:0] a, input logic [7:0] c,
                                    input logic [1:0] cnt, input logic done,
                                    input logic [2:0] st);
      index_beat_type beat;
      beat.px_first  = a;
      beat.px_second = c;
      beat.count     = cnt;
      beat.done      = done;
      beat.status    = st;
      beat.last      = 1'b0;
      expected_beats.insert(expected_beats.size(), beat);
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic last_byte);
      logic [7:0]  px [$];
      logic [7:0]  a;
      logic [7:0]  c;
      logic        flush;
      int unsigned lim;
      int unsigned run_len;
      int          i;
      int          n;
      int          rest;
      int          first_new;
      flush = 1'b0;
      lim = effective_region(region_reg);
      first_new = expected_beats.size();
      if (held_valid) begin
         px.insert(px.size(), held_px);
         held_valid = 1'b0;
      end
      if (want_mode) begin
         want_mode = 1'b0;
         pix_pos = 0;
         phase = rxd_pkg::PHASE_TAG;
         lit_left = 8'd0;
         err = rxd_pkg::STAT_OK;
         if (b > rxd_pkg::MODE_RLEXOR) begin
            cur_mode = rxd_pkg::MODE_RAW;
            err = rxd_pkg::STAT_MODE;
         end else begin
            cur_mode = b[1:0];
            if ((cur_mode == rxd_pkg::MODE_XOR || cur_mode == rxd_pkg::MODE_RLEXOR)
                && !have_ref)
               err = rxd_pkg::STAT_NO_REF;
         end
      end else if (err == rxd_pkg::STAT_OK) begin
         if (cur_mode == rxd_pkg::MODE_RAW || cur_mode == rxd_pkg::MODE_XOR) begin
            if (pix_pos >= lim) err = rxd_pkg::STAT_LENGTH;
            else px.insert(px.size(), store_pixel(b));
         end else if (phase == rxd_pkg::PHASE_TAG) begin
            run_len = (b & rxd_pkg::TAG_COUNT_MASK) + 1;
            flush = b[rxd_pkg::TAG_REPEAT_BIT];
            if (pix_pos + run_len > lim) err = rxd_pkg::STAT_OVERRUN;
            else begin
               phase = b[rxd_pkg::TAG_REPEAT_BIT] ? rxd_pkg::PHASE_REPEAT
                                                  : rxd_pkg::PHASE_LITERAL;
               lit_left = 8'(run_len);
            end
         end else if (phase == rxd_pkg::PHASE_REPEAT) begin
            for (i = 0; i < lit_left; i++) px.insert(px.size(), store_pixel(b));
            phase = rxd_pkg::PHASE_TAG;
            lit_left = 8'd0;
         end else begin
            px.insert(px.size(), store_pixel(b));
            lit_left--;
            if (lit_left == 0) phase = rxd_pkg::PHASE_TAG;
         end
      end

      n = px.size();
      i = 0;
      if (last_byte) begin
         if (err == rxd_pkg::STAT_OK) begin
            if ((cur_mode == rxd_pkg::MODE_RLE || cur_mode == rxd_pkg::MODE_RLEXOR)
                && phase != rxd_pkg::PHASE_TAG)
               err = rxd_pkg::STAT_LENGTH;
            else if (pix_pos != lim)
               err = rxd_pkg::STAT_LENGTH;
         end
         if (err == rxd_pkg::STAT_OK) have_ref = 1'b1;
         want_mode = 1'b1;
         phase = rxd_pkg::PHASE_TAG;
         lit_left = 8'd0;
         while (i + 2 < n) begin
            add_beat(px[i], px[i+1], 2'd2, 1'b0, rxd_pkg::STAT_OK);
            i += 2;
         end
         rest = n - i;
         a = 8'h00;
         c = 8'h00;
         if (rest > 0) a = px[i];
         if (rest > 1) c = px[i+1];
         add_beat(a, c, 2'(rest), 1'b1, err);
      end else begin
         while (i + 1 < n) begin
            add_beat(px[i], px[i+1], 2'd2, 1'b0, rxd_pkg::STAT_OK);
            i += 2;
         end
         if (i < n) begin
            if (flush) add_beat(px[i], 8'h00, 2'd1, 1'b0, rxd_pkg::STAT_OK);
            else begin
               held_valid = 1'b1;
               held_px = px[i];
            end
         end
      end
      if (expected_beats.size() > first_new)
         expected_beats[expected_beats.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            decode_byte(req_payload_byte, req_payload_end);
            in_flight = 1'b0;
            items_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending.size() != 0) begin
               next_item = pending.pop_front();
               in_flight = 1'b1;
               req_valid <= 1'b1;
               req_payload_byte <= next_item.data;
               req_payload_end <= next_item.last;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               $error("result transaction with nothing expected");
               mismatch_count++;
            end else begin
               want_beat = expected_beats.pop_front();
               check_field("index_first", want_beat.px_first, rsp_index_first);
               check_field("index_second", want_beat.px_second, rsp_index_second);
               check_field("index_count", 8'(want_beat.count), 8'(rsp_index_count));
               check_field("frame_done", 8'(want_beat.done), 8'(rsp_frame_done));
               check_field("frame_status", 8'(want_beat.status), 8'(rsp_frame_status));
               check_field("run_last", 8'(want_beat.last), 8'(rsp_run_last));
               results_checked++;
               if (want_beat.done && want_beat.status <= rxd_pkg::STAT_OVERRUN)
                  status_tally[want_beat.status]++;
            end
         end
         stall_cycle++;
         if (stall_cycle % 150 == 0) stall_style = ready_style_type'($urandom_range(0, 3));
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_ready <= 1'b0;
         end else if (!long_hold_used && items_accepted >= 60 && pending.size() > 10) begin
            long_hold_used = 1'b1;
            long_hold_left = 500;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_style)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
               READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
               default:      rsp_ready <= (stall_cycle % 3 == 0);
            endcase
         end
      end
   end

   task automatic put_byte(input logic [7:0] data, input logic last);
      payload_item_type item;
      item.data = data;
      item.last = last;
      pending.insert(pending.size(), item);
   endtask

   task automatic wait_drained;
      while (pending.size() != 0 || in_flight || expected_beats.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_region(input logic [16:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_region_pixels <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      region_reg = value;
   endtask

   task automatic prepare_region(input logic [16:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_region(value);
   endtask

   task automatic put_pixels(input int unsigned count);
      int unsigned left;
      int unsigned run;
      left = count;
      while (left > 0) begin
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
         if (run > left) run = left;
         if ($urandom_range(0, 1)) begin
            frame_bytes.insert(frame_bytes.size(), 8'h80 | 8'(run - 1));
            frame_bytes.insert(frame_bytes.size(), 8'($urandom));
         end else begin
            frame_bytes.insert(frame_bytes.size(), 8'(run - 1));
            repeat (run) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
         end
         left -= run;
      end
   endtask

   task automatic make_frame(input int unsigned lim);
      frame_kind_type kind;
      logic [1:0]     mode;
      logic [7:0]     tag;
      int unsigned    count;
      int unsigned    pos;
      int unsigned    run;
      int             pick;
      int             i;
      pick = $urandom_range(0, 9);
      if (pick < 7) kind = FRAME_GOOD;
      else if (pick == 7) kind = FRAME_BAD_MODE;
      else if (pick == 8) kind = FRAME_BAD_LENGTH;
      else kind = FRAME_BAD_PACKET;
      if (lim > 200 && kind == FRAME_GOOD) kind = FRAME_BAD_LENGTH;
      mode = 2'($urandom_range(0, 3));
      // keep XOR frames inside the part of the reference already written
      if (lim > gen_prefix) mode[0] = 1'b0;
      if (kind == FRAME_BAD_PACKET) mode[1] = 1'b1;
      frame_bytes.delete();
      case (kind)
         FRAME_BAD_MODE: begin
            frame_bytes.insert(frame_bytes.size(),
                               8'($urandom_range(rxd_pkg::MODE_RLEXOR + 1, 255)));
            repeat ($urandom_range(0, 3))
               frame_bytes.insert(frame_bytes.size(), 8'($urandom));
         end
         FRAME_BAD_PACKET: begin
            frame_bytes.insert(frame_bytes.size(), 8'(mode));
            if (lim > 200) pos = $urandom_range(0, 6);
            else pos = (lim > 1) ? $urandom_range(0, lim - 1) : 0;
            put_pixels(pos);
            if (lim - pos < 128 && $urandom_range(0, 1)) begin
               run = $urandom_range(lim - pos + 1, 128);
               tag = 8'(run - 1);
               tag[rxd_pkg::TAG_REPEAT_BIT] = 1'($urandom_range(0, 1));
               frame_bytes.insert(frame_bytes.size(), tag);
            end else begin
               run = $urandom_range(2, 8);
               tag = 8'(run - 1);
               tag[rxd_pkg::TAG_REPEAT_BIT] = 1'($urandom_range(0, 1));
               frame_bytes.insert(frame_bytes.size(), tag);
               if (!tag[rxd_pkg::TAG_REPEAT_BIT])
                  repeat ($urandom_range(0, run - 1))
                     frame_bytes.insert(frame_bytes.size(), 8'($urandom));
            end
         end
         default: begin
            count = lim;
            if (kind == FRAME_BAD_LENGTH) begin
               count = $urandom_range(0, (lim > 200) ? 6 : lim + 3);
               if (count == lim) count++;
            end
            frame_bytes.insert(frame_bytes.size(), 8'(mode));
            if (mode[1]) put_pixels(count);
            else repeat (count) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
         end
      endcase
      if (kind == FRAME_GOOD && lim > gen_prefix) gen_prefix = lim;
      for (i = 0; i < frame_bytes.size(); i++)
         put_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   task automatic random_phase(input logic [16:0] value);
      int unsigned lim;
      int          phase_items;
      prepare_region(value);
      lim = effective_region(value);
      phase_items = 0;
      while (phase_items < 30) begin
         make_frame(lim);
         phase_items += frame_bytes.size();
      end
      random_items += phase_items;
   endtask

   task automatic full_size_phase;
      int i;
      // clamp the all-ones region to the largest frame; end long repeats early
      prepare_region(17'h1FFFF);
      put_byte(8'(rxd_pkg::MODE_RLE), 1'b0);
      for (i = 0; i < 4; i++) begin
         put_byte(8'hFF, 1'b0);
         put_byte(8'($urandom), i == 3);
      end
      put_byte(8'(rxd_pkg::MODE_XOR), 1'b0);
      put_byte(8'($urandom), 1'b0);
      put_byte(8'($urandom), 1'b1);
      put_byte(8'hFF, 1'b1);
   endtask

   initial begin
      int          phase_no;
      int          pick;
      logic [16:0] value;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_region(17'd3);

      put_byte(8'(rxd_pkg::MODE_RLEXOR), 1'b1);
      put_byte(8'hFF, 1'b1);
      put_byte(8'(rxd_pkg::MODE_RAW), 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(8'hFF, 1'b0);
      put_byte(8'h80, 1'b1);
      put_byte(8'(rxd_pkg::MODE_XOR), 1'b0);
      put_byte(8'hFF, 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(8'h7F, 1'b1);
      gen_prefix = 3;
      // hold a literal pixel, then flush it alone on the repeat tag
      put_byte(8'(rxd_pkg::MODE_RLE), 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(8'h11, 1'b0);
      wait_drained();
      put_byte(8'h81, 1'b0);
      put_byte(8'h22, 1'b1);
      put_byte(8'(rxd_pkg::MODE_RLEXOR), 1'b0);
      put_byte(8'h82, 1'b0);
      put_byte(8'h33, 1'b1);
      put_byte(8'(rxd_pkg::MODE_RLE), 1'b0);
      put_byte(8'hFF, 1'b1);
      put_byte(8'(rxd_pkg::MODE_XOR), 1'b0);
      put_byte(8'h01, 1'b0);
      put_byte(8'h02, 1'b0);
      put_byte(8'h03, 1'b0);
      put_byte(8'h04, 1'b1);
      put_byte(8'(rxd_pkg::MODE_RLE), 1'b0);
      put_byte(8'h01, 1'b0);
      put_byte(8'h44, 1'b1);

      for (phase_no = 0; phase_no < 6 || random_items < 210; phase_no++) begin
         if (phase_no == 1) random_phase(17'd0);
         else if (phase_no == 3) full_size_phase();
         else if (phase_no == 5) random_phase(17'd65536);
         else begin
            pick = $urandom_range(0, 9);
            if (pick < 6) value = 17'($urandom_range(1, 12));
            else if (pick < 8) value = 17'($urandom_range(13, 40));
            else if (pick == 8) value = 17'($urandom_range(41, 150));
            else value = 17'd1;
            random_phase(value);
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d payload bytes and %0d result transactions over %0d phases",
               items_accepted, results_checked, phase_no);
      $display("Frames closed: ok %0d, length %0d, mode %0d, no reference %0d, overrun %0d",
               status_tally[0], status_tally[1], status_tally[2], status_tally[3],
               status_tally[4]);
      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/rxd_pkg.sv
rtl/core/rxd_ctrl.sv
rtl/core/rxd_datapath.sv
rtl/core/rle_xor_delta_frame_decoder_unit.sv
rtl/core/rxd_checker.sv
tb/sv/rle_xor_delta_frame_decoder_unit_test.sv
